>>> rtl/ipsp_pkg.sv
// Constants, row layout and result type shared by the stride prefetcher.
`default_nettype none
package ipsp_pkg;

  localparam int ADDR_W         = 48;
  localparam int ENTRIES        = 256;
  localparam int ADDR_BITS      = 48;
  localparam int ADDR_LOW_BITS  = 12;
  localparam int STRIDE_BITS    = 8;
  localparam int LAST_PF_BITS   = 12;
  localparam int CONF_BITS      = 2;

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int LA_EFF   = (ADDR_LOW_BITS < ADDR_BITS) ? ADDR_LOW_BITS : ADDR_BITS;

  localparam logic [CONF_BITS-1:0] CONF_MAX = {CONF_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] LOW_MASK = {ADDR_BITS{1'b1}} >> (ADDR_BITS - LA_EFF);

  typedef struct packed {
    logic [ADDR_LOW_BITS-1:0]  addr_low;
    logic [STRIDE_BITS-1:0]    stride;
    logic [CONF_BITS-1:0]      conf;
    logic [LAST_PF_BITS-1:0]   pf_low;
  } row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefetch_addr;
    logic              prefetch_issue;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/ipsp_table.sv
// Per-row history table: memory with registered read, row valid bits and write bypass.
`default_nettype none
module ipsp_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [ipsp_pkg::IDX_BITS-1:0] rd_idx,
  output ipsp_pkg::row_t                     rd_row,
  input  wire logic                          wr_en,
  input  wire logic [ipsp_pkg::IDX_BITS-1:0] wr_idx,
  input  ipsp_pkg::row_t                     wr_row
);

  ipsp_pkg::row_t                   mem [ipsp_pkg::ENTRIES];
  logic [ipsp_pkg::ENTRIES-1:0]     valid;
  ipsp_pkg::row_t                   mem_q;
  logic                             mem_q_valid;
  ipsp_pkg::row_t                   fwd_row;
  logic                             fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_idx];
      fwd_row <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      mem_q_valid <= 1'b0;
      fwd         <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        mem_q_valid <= valid[rd_idx];
        fwd         <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  // rows never written since reset read as zero
  assign rd_row = fwd ? fwd_row : (mem_q_valid ? mem_q : '0);

endmodule
`default_nettype wire

>>> rtl/ipsp_update.sv
// Stride, confidence and proposal logic for one access against its table row.
`default_nettype none
module ipsp_update (
  input  wire logic [ipsp_pkg::ADDR_W-1:0] access_addr,
  input  ipsp_pkg::row_t                   old_row,
  output ipsp_pkg::row_t                   new_row,
  output ipsp_pkg::result_t                result
);

  logic [ipsp_pkg::ADDR_BITS-1:0]   addr;
  logic [ipsp_pkg::ADDR_BITS-1:0]   prev;
  logic [ipsp_pkg::ADDR_BITS-1:0]   diff;
  logic [ipsp_pkg::STRIDE_BITS-1:0] stride;
  logic [ipsp_pkg::CONF_BITS-1:0]   conf;
  logic [ipsp_pkg::ADDR_BITS-1:0]   pf_sum;
  logic [ipsp_pkg::ADDR_BITS-1:0]   pf;
  logic [ipsp_pkg::ADDR_W-1:0]      pf_out;

  always_comb begin
    addr   = ipsp_pkg::ADDR_BITS'(access_addr);
    prev   = (addr & ~ipsp_pkg::LOW_MASK)
           | (ipsp_pkg::ADDR_BITS'(old_row.addr_low) & ipsp_pkg::LOW_MASK);
    diff   = addr - prev;
    stride = ipsp_pkg::STRIDE_BITS'(diff);

    if (stride == old_row.stride) begin
      conf = (old_row.conf == ipsp_pkg::CONF_MAX) ? old_row.conf
                                                  : old_row.conf + 1'b1;
    end else begin
      conf = '0;
    end

    pf_sum = addr + ipsp_pkg::ADDR_BITS'(stride);
    pf     = '0;

    new_row.addr_low = ipsp_pkg::ADDR_LOW_BITS'(addr & ipsp_pkg::LOW_MASK);
    new_row.stride   = stride;
    new_row.conf     = conf;
    new_row.pf_low   = old_row.pf_low;

    if (conf == ipsp_pkg::CONF_MAX) begin
      // a proposal whose low bits repeat the last proposal is dropped
      if (ipsp_pkg::LAST_PF_BITS'(pf_sum) != old_row.pf_low) begin
        pf = pf_sum;
      end
      new_row.pf_low = ipsp_pkg::LAST_PF_BITS'(pf);
    end

    pf_out                = ipsp_pkg::ADDR_W'(pf);
    result.prefetch_addr  = pf_out;
    result.prefetch_issue = (pf_out != '0);
  end

endmodule
`default_nettype wire

>>> rtl/ip_stride_prefetcher.sv
// Top level of the instruction-address stride prefetcher.
//
//   channel | signals                              | dir
//   --------+--------------------------------------+-----
//   request | in_valid, in_stall, pc, access_addr  | in
//   result  | out_valid, out_stall, prefetch_addr, | out
//           | prefetch_issue                       |
//
// One request per cycle when not stalled; lookup and output are registered.
// The table read is registered; the row update is written back as the
// request leaves the lookup stage, and a write-to-read bypass serves a
// request to the same row accepted in the same cycle as that write.
// Reset clears the row valid bits at once; no clearing pass is needed.
// A stalled result holds the lookup stage, which then stalls the input.
`default_nettype none
module ip_stride_prefetcher (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ipsp_pkg::ADDR_W-1:0] pc,
  input  wire logic [ipsp_pkg::ADDR_W-1:0] access_addr,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ipsp_pkg::ADDR_W-1:0]      prefetch_addr,
  output logic                             prefetch_issue
);

  logic                          accept;
  logic                          advance;
  logic [ipsp_pkg::IDX_BITS-1:0] idx_masked;
  logic [ipsp_pkg::IDX_BITS-1:0] idx;

  logic                          s1_valid;
  logic [ipsp_pkg::IDX_BITS-1:0] s1_idx;
  logic [ipsp_pkg::ADDR_W-1:0]   s1_addr;

  ipsp_pkg::row_t                old_row;
  ipsp_pkg::row_t                new_row;
  ipsp_pkg::result_t             result;
  ipsp_pkg::result_t             out_q;

  assign idx_masked = pc[ipsp_pkg::IDX_BITS-1:0]
                    & ipsp_pkg::IDX_BITS'(ipsp_pkg::ENTRIES - 1);
  assign idx = ({1'b0, idx_masked} >= (ipsp_pkg::IDX_BITS+1)'(ipsp_pkg::ENTRIES))
             ? idx_masked - ipsp_pkg::IDX_BITS'(ipsp_pkg::ENTRIES) : idx_masked;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  ipsp_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (idx),
    .rd_row (old_row),
    .wr_en  (s1_valid && advance),
    .wr_idx (s1_idx),
    .wr_row (new_row)
  );

  ipsp_update u_update (
    .access_addr (s1_addr),
    .old_row     (old_row),
    .new_row     (new_row),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx  <= idx;
      s1_addr <= access_addr;
    end
    if (advance && s1_valid) begin
      out_q <= result;
    end
  end

  assign prefetch_addr  = out_q.prefetch_addr;
  assign prefetch_issue = out_q.prefetch_issue;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the instruction-address stride prefetcher.
`timescale 1ns / 1ps

module tb_top;

  localparam int ADDR_W        = ipsp_pkg::ADDR_W;
  localparam int ADDR_BITS     = ipsp_pkg::ADDR_BITS;
  localparam int ENTRIES       = ipsp_pkg::ENTRIES;
  localparam int ADDR_LOW_BITS = ipsp_pkg::ADDR_LOW_BITS;
  localparam int STRIDE_BITS   = ipsp_pkg::STRIDE_BITS;
  localparam int CONF_BITS     = ipsp_pkg::CONF_BITS;
  localparam int LAST_PF_BITS  = ipsp_pkg::LAST_PF_BITS;
  localparam int IDX_BITS      = ipsp_pkg::IDX_BITS;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ADDR_W-1:0] pc = '0;
  logic [ADDR_W-1:0] access_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] prefetch_addr;
  logic              prefetch_issue;

  ip_stride_prefetcher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pc(pc),
    .access_addr(access_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .prefetch_addr(prefetch_addr),
    .prefetch_issue(prefetch_issue)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Per-row history, mirrors the table
  logic [ADDR_LOW_BITS-1:0]  last_addr_low [ENTRIES];
  logic [STRIDE_BITS-1:0]    hist_stride   [ENTRIES];
  logic [CONF_BITS-1:0]      conf_ctr      [ENTRIES];
  logic [LAST_PF_BITS-1:0]   last_pf_low   [ENTRIES];

  ipsp_pkg::result_t pending_prefetches[$];
  ipsp_pkg::result_t want;

  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int issued_seen = 0;
  int idle_cycles = 0;
  int stall_hold = 0;
  bit steady_flow = 1'b0;

  logic [ADDR_W-1:0] stream_pc   [4] = '{default: '0};
  logic [ADDR_W-1:0] stream_addr [4] = '{default: '0};
  logic [ADDR_W-1:0] stream_step [4] = '{default: '0};
  int                stream_left [4] = '{default: 0};

  function automatic ipsp_pkg::result_t predict_prefetch(input logic [ADDR_W-1:0] p,
                                                         input logic [ADDR_W-1:0] a);
    int unsigned            row;
    logic [ADDR_BITS-1:0]   addr;
    logic [ADDR_BITS-1:0]   prev;
    logic [ADDR_BITS-1:0]   diff;
    logic [ADDR_BITS-1:0]   pf;
    logic [STRIDE_BITS-1:0] stride;
    ipsp_pkg::result_t      r;
    row = int'((p & (ENTRIES - 1)) % ENTRIES);
    addr = a;
    prev = {addr[ADDR_BITS-1:ADDR_LOW_BITS], last_addr_low[row]};
    diff = addr - prev;
    stride = diff[STRIDE_BITS-1:0];
    if (stride == hist_stride[row]) begin
      if (conf_ctr[row] != ipsp_pkg::CONF_MAX) conf_ctr[row] = conf_ctr[row] + 1'b1;
    end else begin
      conf_ctr[row] = '0;
    end
    last_addr_low[row] = addr[ADDR_LOW_BITS-1:0];
    hist_stride[row] = stride;
    pf = '0;
    if (conf_ctr[row] == ipsp_pkg::CONF_MAX) begin
      pf = addr + stride;
      if (pf[LAST_PF_BITS-1:0] == last_pf_low[row]) pf = '0;
      last_pf_low[row] = pf[LAST_PF_BITS-1:0];
    end
    r.prefetch_addr = pf;
    r.prefetch_issue = (pf != '0);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_W-1:0];
  endfunction

  // Mostly short waits, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] p, input logic [ADDR_W-1:0] a);
    int gap;
    gap = steady_flow ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pc <= p;
    access_addr <= a;
    do @(posedge clk); while (in_stall);
    pending_prefetches.push_back(predict_prefetch(p, a));
    items_sent++;
  endtask

  task automatic new_stream(input int i);
    logic [ADDR_W-1:0] p;
    int k;
    p = rand_addr();
    if ($urandom_range(0, 3) == 0)
      p[IDX_BITS-1:0] = stream_pc[$urandom_range(0, 3)][IDX_BITS-1:0];
    stream_pc[i] = p;
    stream_addr[i] = rand_addr();
    if ($urandom_range(0, 19) == 0)
      stream_addr[i] = {{(ADDR_W-12){1'b1}}, 12'($urandom())};
    case ($urandom_range(0, 9))
      0: k = 0;
      1: k = $urandom_range(256, 4095);
      default: k = $urandom_range(1, 128);
    endcase
    stream_step[i] = ADDR_W'(k);
    if ($urandom_range(0, 1) == 1) stream_step[i] = -stream_step[i];
    stream_left[i] = $urandom_range(5, 20);
  endtask

  task automatic test_field_extremes();
    send_request('0, '0);
    send_request('1, '1);
    send_request('1, '0);
    send_request('0, '1);
    send_request({(ADDR_W/2){2'b01}}, {(ADDR_W/2){2'b10}});
  endtask

  // Zero stride on one address: proposal, then suppressed repeat, then again
  task automatic test_repeated_proposal();
    repeat (7) send_request(48'h0000_0000_0022, 48'h1234_5678_9ABC);
  endtask

  // Stride 8 walking up to the top of the address space
  task automatic test_wrap_to_zero();
    logic [ADDR_W-1:0] a;
    a = 48'hFFFF_FFFF_FFD0;
    repeat (6) begin
      send_request(48'h0000_0000_0033, a);
      a = a + 8;
    end
  endtask

  // Two instruction addresses that differ only above the index share a row
  task automatic test_row_aliasing();
    send_request(48'h0000_0000_0044, 48'h0000_0000_1100);
    send_request(48'hFFFF_FFFF_FF44, 48'h0000_0000_1140);
    send_request(48'h0000_0000_0044, 48'h0000_0000_1180);
    send_request(48'hFFFF_FFFF_FF44, 48'h0000_0000_11C0);
  endtask

  // Interleaved strided streams, with noise and skipped accesses mixed in
  task automatic test_random_streams(input int n);
    int i;
    int pick;
    for (i = 0; i < 4; i++) new_stream(i);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_request(rand_addr(), rand_addr());
      end else begin
        i = $urandom_range(0, 3);
        if (pick < 17) stream_addr[i] = stream_addr[i] + stream_step[i];
        send_request(stream_pc[i], stream_addr[i]);
        stream_addr[i] = stream_addr[i] + stream_step[i];
        stream_left[i]--;
        if (stream_left[i] == 0) new_stream(i);
      end
    end
  endtask

  task automatic test_full_rate(input int n);
    steady_flow = 1'b1;
    test_random_streams(n);
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || steady_flow) begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 20);
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= !out_stall;
      if (out_stall) begin
        stall_hold <= ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 20);
      end else begin
        stall_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(7, 29);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (prefetch_issue) issued_seen++;
      if (pending_prefetches.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got addr %h issue %b",
                   $time, prefetch_addr, prefetch_issue);
      end else begin
        want = pending_prefetches.pop_front();
        if (prefetch_addr !== want.prefetch_addr) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: prefetch_addr mismatch, expected %h, got %h",
                     $time, want.prefetch_addr, prefetch_addr);
        end
        if (prefetch_issue !== want.prefetch_issue) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: prefetch_issue mismatch, expected %b, got %b",
                     $time, want.prefetch_issue, prefetch_issue);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int r = 0; r < ENTRIES; r++) begin
      last_addr_low[r] = '0;
      hist_stride[r] = '0;
      conf_ctr[r] = '0;
      last_pf_low[r] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_repeated_proposal();
    test_wrap_to_zero();
    test_row_aliasing();
    test_random_streams(700);
    test_full_rate(100);

    in_valid <= 1'b0;
    while (pending_prefetches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (directed and strided streams), %0d results, %0d issued.",
             items_sent, results_seen, issued_seen);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             fail_count, pending_prefetches.size());
    if (fail_count == 0 && pending_prefetches.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
